FILE: rtl/dmcf_pkg.sv
// Shared types and constants for the dual magnetometer calibration and fusion block.
package dmcf_pkg;

  // One input item: a raw X/Y/Z sample from each magnetometer.
  typedef struct packed {
    logic signed [15:0] raw0_x;
    logic signed [15:0] raw0_y;
    logic signed [15:0] raw0_z;
    logic signed [15:0] raw1_x;
    logic signed [15:0] raw1_y;
    logic signed [15:0] raw1_z;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic signed [15:0] cal0_x;
    logic signed [15:0] cal0_y;
    logic signed [15:0] cal0_z;
    logic signed [15:0] cal1_x;
    logic signed [15:0] cal1_y;
    logic signed [15:0] cal1_z;
    logic signed [15:0] fused_x;
    logic signed [15:0] fused_y;
    logic signed [15:0] fused_z;
    logic               interference;
    logic               heading_available;
  } result_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_CALIBRATED = 3'd0;
  localparam logic [2:0] REG_OFFSETS0   = 3'd1;
  localparam logic [2:0] REG_SCALES0    = 3'd2;
  localparam logic [2:0] REG_OFFSETS1   = 3'd3;
  localparam logic [2:0] REG_SCALES1    = 3'd4;

  // Unit scale in Q2.14 on every axis, packed z:y:x.
  localparam logic [15:0] SCALE_ONE   = 16'h4000;
  localparam logic [47:0] SCALES_UNIT = {SCALE_ONE, SCALE_ONE, SCALE_ONE};

  // cos(10 deg) in Q30.
  localparam logic [43:0] COS10_Q30 = 44'd1057429273;

endpackage

FILE: rtl/dual_magnetometer_calibrate_fuse.sv
// Top level of the dual magnetometer calibration and fusion pipeline.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   sample   | in        | sample_valid/sample_stall | sample_t, six raw axes
//   result   | out       | result_valid/result_stall | result_t, vectors + flags
//   cfg      | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One item enters per cycle while the pipeline is not stalled. Each path runs through
// two normalizers, each with a square root chain, one bit per stage, and a division
// chain, one quotient bit per stage.
// Reset clears the valid bits and loads offsets 0, unit scales, calibration off.
// A stalled result freezes the whole pipeline; sample_stall follows it directly.
module dual_magnetometer_calibrate_fuse import dmcf_pkg::*; #(
  parameter int FRACTION_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int SW_F  = 98;
  localparam int SH    = 2 * FRACTION_BITS - 30;
  localparam int SHL   = (SH > 0) ? SH : 0;
  localparam int SHR   = (SH < 0) ? -SH : 0;
  localparam logic signed [43:0] THR = (COS10_Q30 << SHL) >> SHR;

  // Configuration registers.
  logic        calibrated;
  logic [47:0] offsets0;
  logic [47:0] scales0;
  logic [47:0] offsets1;
  logic [47:0] scales1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated <= 1'b0;
      offsets0   <= '0;
      scales0    <= SCALES_UNIT;
      offsets1   <= '0;
      scales1    <= SCALES_UNIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CALIBRATED: calibrated <= cfg_data[0];
        REG_OFFSETS0:   offsets0   <= cfg_data;
        REG_SCALES0:    scales0    <= cfg_data;
        REG_OFFSETS1:   offsets1   <= cfg_data;
        REG_SCALES1:    scales1    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held back.
  logic en;

  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // Offset, scale and drop to Q.10 for one axis.
  function automatic logic [28:0] cal_axis(input logic [15:0] raw, input logic [15:0] off,
                                           input logic [15:0] scl);
    logic signed [16:0] a;
    logic signed [33:0] p;
    a = 17'($signed(raw)) + 17'($signed(off));
    p = a * $signed({1'b0, scl});
    return 29'(p >>> 4);
  endfunction

  // Round a Q.10 value to LSB, half up, and saturate.
  function automatic logic [15:0] round_sat(input logic [28:0] v);
    logic signed [29:0] x;
    x = 30'($signed(v)) + 30'sd512;
    x = x >>> 10;
    if (x > 30'sd32767) begin
      return 16'h7fff;
    end else if (x < -30'sd32768) begin
      return 16'h8000;
    end else begin
      return x[15:0];
    end
  endfunction

  // Calibration stage.
  logic [2:0][15:0] raw0;
  logic [2:0][15:0] raw1;
  logic [2:0][28:0] t0_v0;
  logic [2:0][28:0] t0_v1;
  logic             t0_valid;

  assign raw0 = {sample.raw0_z, sample.raw0_y, sample.raw0_x};
  assign raw1 = {sample.raw1_z, sample.raw1_y, sample.raw1_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_valid <= 1'b0;
    end else if (en) begin
      t0_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t0_v0[k] <= cal_axis(raw0[k], offsets0[16*k +: 16], scales0[16*k +: 16]);
        t0_v1[k] <= cal_axis(raw1[k], offsets1[16*k +: 16], scales1[16*k +: 16]);
      end
    end
  end

  // Fallback values for a vector with a zero component.
  logic [2:0][15:0] alt0;
  logic [2:0][15:0] alt1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      alt0[k] = round_sat(t0_v0[k]);
      alt1[k] = round_sat(t0_v1[k]);
    end
  end

  // Per-sensor normalizers.
  logic             n0_valid;
  logic             n1_valid;
  logic [2:0][15:0] n0_vec;
  logic [2:0][15:0] n1_vec;
  logic             n0_cal;
  logic             n1_cal;

  dmcf_norm #(.W(29), .F(FRACTION_BITS), .SW(1)) u_norm0 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t0_valid),
    .vec       (t0_v0),
    .alt       (alt0),
    .side      (calibrated),
    .out_valid (n0_valid),
    .nvec      (n0_vec),
    .nside     (n0_cal)
  );

  dmcf_norm #(.W(29), .F(FRACTION_BITS), .SW(1)) u_norm1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t0_valid),
    .vec       (t0_v1),
    .alt       (alt1),
    .side      (calibrated),
    .out_valid (n1_valid),
    .nvec      (n1_vec),
    .nside     (n1_cal)
  );

  // Dot product terms and per-axis sums.
  logic [2:0][31:0] t1_prod;
  logic [2:0][16:0] t1_s;
  logic [2:0][15:0] t1_c0;
  logic [2:0][15:0] t1_c1;
  logic             t1_cal;
  logic             t1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else if (en) begin
      t1_valid <= n0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t1_prod[k] <= $signed(n0_vec[k]) * $signed(n1_vec[k]);
        t1_s[k]    <= 17'($signed(n0_vec[k])) + 17'($signed(n1_vec[k]));
      end
      t1_c0  <= n0_vec;
      t1_c1  <= n1_vec;
      t1_cal <= n0_cal;
    end
  end

  // Interference test against cos(10 deg).
  logic signed [43:0] dot_c;
  logic [2:0][16:0]   t2_s;
  logic [2:0][15:0]   t2_c0;
  logic [2:0][15:0]   t2_c1;
  logic               t2_intf;
  logic               t2_cal;
  logic               t2_valid;

  assign dot_c = 44'($signed(t1_prod[0])) + 44'($signed(t1_prod[1]))
               + 44'($signed(t1_prod[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else if (en) begin
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_intf <= !(dot_c > THR);
      t2_s    <= t1_s;
      t2_c0   <= t1_c0;
      t2_c1   <= t1_c1;
      t2_cal  <= t1_cal;
    end
  end

  // Fused vector: half the sum when a component is zero, else normalized.
  logic [2:0][15:0] alt_f;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      alt_f[k] = t2_s[k][16:1];
    end
  end

  logic [SW_F-1:0]  f_side;
  logic [2:0][15:0] f_vec;
  logic             f_valid;

  dmcf_norm #(.W(17), .F(FRACTION_BITS), .SW(SW_F)) u_norm_fused (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t2_valid),
    .vec       (t2_s),
    .alt       (alt_f),
    .side      ({t2_cal, t2_intf, t2_c1, t2_c0}),
    .out_valid (f_valid),
    .nvec      (f_vec),
    .nside     (f_side)
  );

  // Result assembly; everything reads zero with calibration off.
  logic             f_cal;
  logic             f_intf;
  logic [2:0][15:0] f_c0;
  logic [2:0][15:0] f_c1;

  assign f_cal  = f_side[97];
  assign f_intf = f_side[96];
  assign f_c1   = f_side[95:48];
  assign f_c0   = f_side[47:0];

  assign result_valid = f_valid;

  always_comb begin
    result = '0;
    if (f_cal) begin
      result.cal0_x            = f_c0[0];
      result.cal0_y            = f_c0[1];
      result.cal0_z            = f_c0[2];
      result.cal1_x            = f_c1[0];
      result.cal1_y            = f_c1[1];
      result.cal1_z            = f_c1[2];
      result.fused_x           = f_vec[0];
      result.fused_y           = f_vec[1];
      result.fused_z           = f_vec[2];
      result.interference      = f_intf;
      result.heading_available = !f_intf;
    end
  end

  // The two sensor normalizers must stay in lockstep.
  a_norm_lockstep: assert property (@(posedge clk) disable iff (rst)
    (n0_valid == n1_valid) && (!n0_valid || (n0_cal == n1_cal)))
    else $error("sensor normalizers out of step");

  // With calibration off, a delivered result is all zero.
  a_cal_off_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !calibrated) |-> (result == '0))
    else $error("nonzero result with calibration off");

  // A usable heading never comes with interference.
  a_heading_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.heading_available) |-> (!result.interference && calibrated))
    else $error("heading available despite interference");

endmodule

FILE: rtl/dmcf_norm.sv
// Pipelined vector normalizer: square root of the sum of squares, then per-axis division.
module dmcf_norm #(
  parameter int W  = 29,
  parameter int F  = 14,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][W-1:0]     vec,
  input  logic [2:0][15:0]      alt,
  input  logic [SW-1:0]         side,
  output logic                  out_valid,
  output logic [2:0][15:0]      nvec,
  output logic [SW-1:0]         nside
);

  localparam int NW    = 2 * W + 2;
  localparam int RW    = W + 1;
  localparam int QW    = F + 1;
  localparam int DW    = W + F + 2;
  localparam int EW    = QW + 16;
  localparam int CW    = 3 * W + 52 + SW;
  localparam int LAT   = RW + QW + 5;
  localparam int O_ALT = SW;
  localparam int O_NZ  = SW + 48;
  localparam int O_NEG = SW + 49;
  localparam int O_MAG = SW + 52;

  // Valid bits travel with the stages.
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  // Sign and magnitude of each component.
  logic [2:0][W-1:0] mag_c;
  logic [2:0]        neg_c;
  logic              nz_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_c[k] = vec[k][W-1];
      mag_c[k] = neg_c[k] ? (~vec[k] + W'(1)) : vec[k];
    end
    nz_c = (|vec[0]) && (|vec[1]) && (|vec[2]);
  end

  logic [CW-1:0]     a_cg;
  logic [2:0][W-1:0] a_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      a_cg  <= {mag_c, neg_c, nz_c, alt, side};
      a_mag <= mag_c;
    end
  end

  // Squares of the magnitudes.
  logic [2:0][2*W-1:0] b_sq;
  logic [CW-1:0]       b_cg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b_sq[k] <= a_mag[k] * a_mag[k];
      end
      b_cg <= a_cg;
    end
  end

  // Sum of squares.
  logic [NW-1:0] c_sum;
  logic [CW-1:0] c_cg;

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum <= NW'(b_sq[0]) + NW'(b_sq[1]) + NW'(b_sq[2]);
      c_cg  <= b_cg;
    end
  end

  // Integer square root, one result bit per stage.
  logic [NW-1:0] rs  [0:RW-2];
  logic [NW-1:0] rr  [0:RW-1];
  logic [CW-1:0] scg [0:RW-1];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam logic [NW:0] BIT = (NW+1)'(1) << (2 * (RW - 1 - j));
    logic [NW-1:0] ps;
    logic [NW-1:0] pr;
    logic [CW-1:0] pc;
    logic [NW:0]   t;
    logic          take;

    if (j == 0) begin : g_first
      assign ps = c_sum;
      assign pr = '0;
      assign pc = c_cg;
    end else begin : g_next
      assign ps = rs[j-1];
      assign pr = rr[j-1];
      assign pc = scg[j-1];
    end

    assign t    = {1'b0, pr} + BIT;
    assign take = {1'b0, ps} >= t;

    always_ff @(posedge clk) begin
      if (en) begin
        if (take) begin
          rr[j] <= NW'({1'b0, pr >> 1} + BIT);
        end else begin
          rr[j] <= pr >> 1;
        end
        scg[j] <= pc;
      end
    end

    if (j < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rs[j] <= take ? NW'({1'b0, ps} - t) : ps;
        end
      end
    end
  end

  // Division setup: numerator is magnitude scaled up plus half the root.
  logic [RW-1:0]      root_c;
  logic [2:0][W-1:0]  mag_d;
  logic [RW-1:0]      d_rd;
  logic [2:0][DW-1:0] d_rem;
  logic [CW-1:0]      d_cg;

  always_comb begin
    root_c = rr[RW-1][RW-1:0];
    if (root_c == '0) begin
      root_c = RW'(1);
    end
    mag_d = scg[RW-1][CW-1:O_MAG];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_rem[k] <= (DW'(mag_d[k]) << F) + DW'(root_c >> 1);
      end
      d_rd <= root_c;
      d_cg <= scg[RW-1];
    end
  end

  // Restoring division, one quotient bit per stage on all three axes.
  logic [2:0][DW-1:0] vrem [0:QW-2];
  logic [RW-1:0]      vrd  [0:QW-2];
  logic [2:0][QW-1:0] vq   [0:QW-1];
  logic [CW-1:0]      vcg  [0:QW-1];

  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int B = QW - 1 - i;
    logic [2:0][DW-1:0] srem;
    logic [2:0][QW-1:0] sq;
    logic [RW-1:0]      srd;
    logic [CW-1:0]      scgo;
    logic [DW-1:0]      trial;
    logic [2:0]         fit;

    if (i == 0) begin : g_first
      assign srem = d_rem;
      assign sq   = '0;
      assign srd  = d_rd;
      assign scgo = d_cg;
    end else begin : g_next
      assign srem = vrem[i-1];
      assign sq   = vq[i-1];
      assign srd  = vrd[i-1];
      assign scgo = vcg[i-1];
    end

    assign trial = DW'(srd) << B;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        fit[k] = srem[k] >= trial;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          vq[i][k] <= fit[k] ? (sq[k] | (QW'(1) << B)) : sq[k];
        end
        vcg[i] <= scgo;
      end
    end

    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            vrem[i][k] <= fit[k] ? (srem[k] - trial) : srem[k];
          end
          vrd[i] <= srd;
        end
      end
    end
  end

  // Apply the sign, saturate, and pick the unnormalized value when a component is zero.
  logic [CW-1:0]      ecg;
  logic [2:0][15:0]   nrm_c;
  logic [2:0]         eneg;
  logic [EW-1:0]      qe;

  always_comb begin
    ecg  = vcg[QW-1];
    eneg = ecg[O_NEG+2:O_NEG];
    qe   = '0;
    for (int k = 0; k < 3; k++) begin
      qe = EW'(vq[QW-1][k]);
      if (eneg[k]) begin
        nrm_c[k] = (qe > EW'(32768)) ? 16'h8000 : 16'(~qe[15:0] + 16'd1);
      end else begin
        nrm_c[k] = (qe > EW'(32767)) ? 16'h7fff : qe[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nvec  <= ecg[O_NZ] ? nrm_c : ecg[O_ALT+47:O_ALT];
      nside <= ecg[SW-1:0];
    end
  end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the dual magnetometer calibration and fusion block.
module tb_top;
  import dmcf_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 2 * FRAC + 63;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_CALIBRATED;
  logic [47:0] cfg_data = '0;

  dual_magnetometer_calibrate_fuse #(.FRACTION_BITS(FRAC)) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic        mdl_cal;
  logic [47:0] mdl_off [2];
  logic [47:0] mdl_scl [2];

  sample_t pending_samples[$];
  result_t expected_results[$];
  int      mismatches = 0;
  bit      hold_input = 0;
  bit      long_hold_request = 0;
  bit      long_hold_done = 0;

  function automatic longint floor_div2n(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint clamp16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale a vector with nonzero components to unit length.
  function automatic void to_unit(input longint v[3], output longint o[3]);
    longint unsigned s, r, m, q;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m = v[k] < 0 ? -v[k] : v[k];
      s += m * m;
    end
    r = int_sqrt(s);
    if (r == 0) r = 1;
    for (int k = 0; k < 3; k++) begin
      m = v[k] < 0 ? -v[k] : v[k];
      q = ((m << FRAC) + r / 2) / r;
      o[k] = clamp16(v[k] < 0 ? -longint'(q) : longint'(q));
    end
  endfunction

  function automatic void apply_cal(input logic signed [15:0] raw[3], input logic [47:0] off,
                                    input logic [47:0] scl, output longint o[3]);
    longint v[3], a;
    bit nz;
    nz = 1;
    for (int k = 0; k < 3; k++) begin
      a = longint'(raw[k]) + longint'($signed(off[16*k +: 16]));
      v[k] = floor_div2n(a * longint'(scl[16*k +: 16]), 4);
      if (v[k] == 0) nz = 0;
    end
    if (nz) to_unit(v, o);
    else for (int k = 0; k < 3; k++) o[k] = clamp16(floor_div2n(v[k] + 512, 10));
  endfunction

  function automatic result_t predict_fusion(sample_t smp);
    result_t r;
    logic signed [15:0] r0[3], r1[3];
    longint c0[3], c1[3], s[3], f[3], dot, thr;
    bit nz;
    r = '0;
    if (!mdl_cal) return r;
    r0 = '{smp.raw0_x, smp.raw0_y, smp.raw0_z};
    r1 = '{smp.raw1_x, smp.raw1_y, smp.raw1_z};
    apply_cal(r0, mdl_off[0], mdl_scl[0], c0);
    apply_cal(r1, mdl_off[1], mdl_scl[1], c1);
    dot = 0;
    nz = 1;
    for (int k = 0; k < 3; k++) begin
      dot += c0[k] * c1[k];
      s[k] = c0[k] + c1[k];
      if (s[k] == 0) nz = 0;
    end
    if (2 * FRAC >= 30) thr = longint'(COS10_Q30) << (2 * FRAC - 30);
    else thr = longint'(COS10_Q30) >> (30 - 2 * FRAC);
    if (nz) to_unit(s, f);
    else for (int k = 0; k < 3; k++) f[k] = floor_div2n(s[k], 1);
    r.cal0_x = 16'(c0[0]); r.cal0_y = 16'(c0[1]); r.cal0_z = 16'(c0[2]);
    r.cal1_x = 16'(c1[0]); r.cal1_y = 16'(c1[1]); r.cal1_z = 16'(c1[2]);
    r.fused_x = 16'(f[0]); r.fused_y = 16'(f[1]); r.fused_z = 16'(f[2]);
    r.interference = !(dot > thr);
    r.heading_available = dot > thr;
    return r;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Sample driver: predicts each item as it is accepted.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      expected_results.push_back(predict_fusion(sample));
      send_gap = short_gap();
      if (send_gap == 0 && pending_samples.size() > 0 && !hold_input) begin
        sample <= pending_samples.pop_front();
      end else begin
        sample_valid <= 1'b0;
      end
    end else if (!sample_valid) begin
      if (send_gap > 0) send_gap--;
      else if (pending_samples.size() > 0 && !hold_input) begin
        sample <= pending_samples.pop_front();
        sample_valid <= 1'b1;
      end
    end
  end

  // Result stall pattern, with one requested long hold-off.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (long_hold_request && !long_hold_done && stall_left == 0) begin
      long_hold_done <= 1'b1;
      stall_left = 300;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= (stall_left > 0);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = short_gap();
      result_stall <= (stall_left > 0);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", result);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, result);
        end
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CALIBRATED: mdl_cal = val[0];
      REG_OFFSETS0: mdl_off[0] = val;
      REG_SCALES0: mdl_scl[0] = val;
      REG_OFFSETS1: mdl_off[1] = val;
      REG_SCALES1: mdl_scl[1] = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random samples; half the time the two sensors point roughly the same way, to reach the no-interference case.
  function automatic sample_t rand_sample();
    sample_t s;
    s = {rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis()};
    if ($urandom_range(0, 1)) begin
      s.raw1_x = s.raw0_x + 16'($signed($urandom_range(0, 64)) - 32);
      s.raw1_y = s.raw0_y + 16'($signed($urandom_range(0, 64)) - 32);
      s.raw1_z = s.raw0_z + 16'($signed($urandom_range(0, 64)) - 32);
    end
    return s;
  endfunction

  function automatic logic [47:0] rand_scales();
    logic [47:0] v;
    for (int k = 0; k < 3; k++)
      case ($urandom_range(0, 3))
        0: v[16*k +: 16] = 16'($urandom);
        1: v[16*k +: 16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: v[16*k +: 16] = 16'($urandom_range(16'h3000, 16'h5000));
      endcase
    return v;
  endfunction

  function automatic logic [47:0] rand_offsets();
    if ($urandom_range(0, 3) == 0) return {$urandom, 16'($urandom)};
    return {16'($signed($urandom_range(0, 400)) - 200),
            16'($signed($urandom_range(0, 400)) - 200),
            16'($signed($urandom_range(0, 400)) - 200)};
  endfunction

  initial begin
    mdl_cal = 1'b0;
    mdl_off = '{48'd0, 48'd0};
    mdl_scl = '{SCALES_UNIT, SCALES_UNIT};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Calibration off: everything reads zero.
    pending_samples.push_back({16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h1234, 16'h0000});
    pending_samples.push_back(rand_sample());
    wait_drained();

    cfg_write(REG_CALIBRATED, 48'hFFFF_FFFF_FFFF);
    // Directed: extremes, zero components, identical and opposite sensors.
    pending_samples.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    pending_samples.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    pending_samples.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    pending_samples.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    pending_samples.push_back({16'h0000, 16'h0100, 16'h0200, 16'h0100, 16'h0000, 16'h0200});
    pending_samples.push_back({16'h0200, 16'h0000, 16'h0000, 16'hFE00, 16'h0000, 16'h0000});
    pending_samples.push_back({16'd1000, 16'd2000, 16'd3000, 16'd1000, 16'd2000, 16'd3000});
    pending_samples.push_back({16'd1000, 16'd2000, 16'd3000, -16'sd1000, -16'sd2000,
                               -16'sd3000});
    pending_samples.push_back({16'h0001, 16'h0001, 16'h0001, 16'hFFFF, 16'h0001, 16'h0001});
    pending_samples.push_back({16'd5000, 16'd0, 16'd5, -16'sd5000, 16'd0, -16'sd5});
    wait_drained();

    // Extreme registers.
    cfg_write(REG_OFFSETS0, 48'h7FFF_8000_7FFF);
    cfg_write(REG_SCALES0, 48'hFFFF_FFFF_FFFF);
    cfg_write(REG_OFFSETS1, 48'h8000_7FFF_8000);
    cfg_write(REG_SCALES1, 48'h0000_0001_FFFF);
    for (int i = 0; i < 12; i++) pending_samples.push_back(rand_sample());
    wait_drained();

    // Random phases with new settings.
    for (int p = 0; p < 8; p++) begin
      cfg_write(REG_CALIBRATED, (p == 5) ? 48'd0 : 48'd1);
      cfg_write(REG_OFFSETS0, (p == 0) ? 48'd0 : rand_offsets());
      cfg_write(REG_SCALES0, (p == 0) ? SCALES_UNIT : rand_scales());
      cfg_write(REG_OFFSETS1, (p == 0) ? 48'd0 : rand_offsets());
      cfg_write(REG_SCALES1, (p == 0) ? SCALES_UNIT : rand_scales());
      for (int i = 0; i < 175; i++) pending_samples.push_back(rand_sample());
      if (p == 2) begin
        // Back up the pipeline while the sender keeps offering.
        long_hold_request = 1'b1;
      end
      if (p == 4) begin
        // Sender pause until all outstanding results have come back.
        while (pending_samples.size() > 90) @(posedge clk);
        hold_input = 1'b1;
        while (sample_valid || expected_results.size() > 0) @(posedge clk);
        hold_input = 1'b0;
      end
      wait_drained();
    end

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/dmcf_pkg.sv
rtl/dmcf_norm.sv
rtl/dual_magnetometer_calibrate_fuse.sv
bench/tb_top.sv
